@@ sv/assert_macros.svh @@
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/imd_pkg.sv @@
// types, constants and helper functions of the icmp message decoder
package imd_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int SUM_COUNT_BITS     = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int NUM_TIME_WORDS     = 3;

   localparam int HEADER_BYTES   = 4;
   localparam int FIXED_BODY_END = 8;
   localparam int TS_BODY_END    = 20;

   localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
   localparam logic [7:0] TYPE_UNREACHABLE  = 8'd3;
   localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
   localparam logic [7:0] TYPE_TS_REQUEST   = 8'd13;
   localparam logic [7:0] TYPE_TS_REPLY     = 8'd14;
   localparam logic [7:0] CODE_ZERO         = 8'd0;
   localparam logic [7:0] CODE_UNREACH_MAX  = 8'd2;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_SHORT_HEADER = 3'd1,
      STATUS_SHORT_BODY   = 3'd2,
      STATUS_TRAILING     = 3'd3,
      STATUS_CHECKSUM_BAD = 3'd4
   } status_type;

   // per-message summary handed from front to back
   typedef struct packed {
      logic [SUM_COUNT_BITS-1:0] byte_count;
      logic [15:0]               sum;
      logic [7:0]                pending;
      logic                      odd;
      logic [15:0]               type_code;
      logic [31:0]               id_seq;
      logic [31:0]               time0;
      logic [31:0]               time1;
      logic [31:0]               time2;
   } summary_type;

   // ones-complement 16-bit add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

@@ sv/imd_if.sv @@
// request and response channel interfaces of the icmp message decoder
interface imd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface imd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        matched;
   logic [7:0]  msg_type;
   logic [7:0]  msg_code;
   logic [15:0] identifier;
   logic [15:0] sequence_number;
   logic [31:0] originate_time;
   logic [31:0] receive_time;
   logic [31:0] transmit_time;
   logic [31:0] unused_word;
   logic [15:0] payload_length;

   modport source (output valid, output status, output matched, output msg_type,
                   output msg_code, output identifier, output sequence_number,
                   output originate_time, output receive_time, output transmit_time,
                   output unused_word, output payload_length, input ready);
   modport sink   (input valid, input status, input matched, input msg_type,
                   input msg_code, input identifier, input sequence_number,
                   input originate_time, input receive_time, input transmit_time,
                   input unused_word, input payload_length, output ready);
endinterface

@@ sv/imd_front.sv @@
// byte front end: field capture, byte count and running checksum
`include "assert_macros.svh"

module imd_front #(
   parameter int COUNT_BITS = imd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   imd_req_if.sink              req,
   input  logic                 q_ready,
   output logic                 q_push,
   output imd_pkg::summary_type q_data
);
   import imd_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int TIDX_BITS = $clog2(NUM_TIME_WORDS);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            pending_ff, pending_in;
   logic                  odd_ff, odd_in;
   logic [15:0]           type_code_ff, type_code_in;
   logic [31:0]           id_seq_ff, id_seq_in;
   logic [31:0]           time_ff [NUM_TIME_WORDS];
   logic [31:0]           time_in [NUM_TIME_WORDS];

   logic                  accept;
   logic [COUNT_BITS-1:0] offset;
   logic [TIDX_BITS-1:0]  tidx;

   assign req.ready = q_ready;
   assign accept    = req.valid && q_ready;
   assign q_push    = accept && req.last_byte;
   assign offset    = count_ff - COUNT_BITS'(FIXED_BODY_END);
   assign tidx      = offset[TIDX_BITS+1:2];

   always_comb begin
      count_in     = count_ff;
      sum_in       = sum_ff;
      pending_in   = pending_ff;
      odd_in       = odd_ff;
      type_code_in = type_code_ff;
      id_seq_in    = id_seq_ff;
      time_in      = time_ff;
      if (accept) begin
         if (count_ff < COUNT_BITS'(2)) begin
            type_code_in = {type_code_ff[7:0], req.data_byte};
         end else if (count_ff >= COUNT_BITS'(HEADER_BYTES)
                      && count_ff < COUNT_BITS'(FIXED_BODY_END)) begin
            id_seq_in = {id_seq_ff[23:0], req.data_byte};
         end else if (count_ff >= COUNT_BITS'(FIXED_BODY_END)
                      && count_ff < COUNT_BITS'(TS_BODY_END)) begin
            time_in[tidx] = {time_ff[tidx][23:0], req.data_byte};
         end
         if (odd_ff) begin
            sum_in = ones_add(sum_ff, {pending_ff, req.data_byte});
         end else begin
            pending_in = req.data_byte;
         end
         odd_in = !odd_ff;
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_comb begin
      q_data.byte_count = SUM_COUNT_BITS'(count_in);
      q_data.sum        = sum_in;
      q_data.pending    = pending_in;
      q_data.odd        = odd_in;
      q_data.type_code  = type_code_in;
      q_data.id_seq     = id_seq_in;
      q_data.time0      = time_in[0];
      q_data.time1      = time_in[1];
      q_data.time2      = time_in[2];
   end

   // a finished message leaves the front fully cleared
   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         pending_ff   <= '0;
         odd_ff       <= 1'b0;
         type_code_ff <= '0;
         id_seq_ff    <= '0;
         for (int i = 0; i < NUM_TIME_WORDS; i++) begin
            time_ff[i] <= '0;
         end
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         pending_ff   <= pending_in;
         odd_ff       <= odd_in;
         type_code_ff <= type_code_in;
         id_seq_ff    <= id_seq_in;
         time_ff      <= time_in;
      end
   end

   `ASSERT_NEXT(a_clear_after_last, clock, reset, q_push, count_ff == '0 && !odd_ff)

endmodule

@@ sv/imd_queue.sv @@
// small summary queue between front and back
`include "assert_macros.svh"

module imd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  imd_pkg::summary_type push_data,
   output logic                 push_ready,
   output logic                 pop_valid,
   input  logic                 pop,
   output imd_pkg::summary_type pop_data
);
   import imd_pkg::*;

   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   summary_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   assign push_ready = fill_ff != FILL_BITS'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                             : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                             : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push, push_ready)
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, pop_valid)
   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_BITS'(QUEUE_DEPTH))

endmodule

@@ sv/imd_back.sv @@
// back end: classify type and code, check lengths and checksum, hold result
`include "assert_macros.svh"

module imd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  imd_pkg::summary_type q_data,
   output logic                 q_pop,
   imd_rsp_if.source            rsp
);
   import imd_pkg::*;

   logic        load;
   logic        rsp_valid_ff;
   status_type  status_d;
   logic        matched_d;
   logic [7:0]  type_d, code_d;
   logic [15:0] ident_d, seq_d, plen_d;
   logic [31:0] orig_d, recv_d, xmit_d, unused_d;

   logic [2:0]  status_ff;
   logic        matched_ff;
   logic [7:0]  type_ff, code_ff;
   logic [15:0] ident_ff, seq_ff, plen_ff;
   logic [31:0] orig_ff, recv_ff, xmit_ff, unused_ff;

   logic [SUM_COUNT_BITS-1:0] cnt;
   logic [7:0]  t, c;
   logic        is_echo, is_unr, is_ts;
   logic [15:0] final_sum;

   assign load  = q_valid && (!rsp_valid_ff || rsp.ready);
   assign q_pop = load;

   assign cnt     = q_data.byte_count;
   assign t       = q_data.type_code[15:8];
   assign c       = q_data.type_code[7:0];
   assign is_echo = c == CODE_ZERO && (t == TYPE_ECHO_REPLY || t == TYPE_ECHO_REQUEST);
   assign is_unr  = t == TYPE_UNREACHABLE && c <= CODE_UNREACH_MAX;
   assign is_ts   = c == CODE_ZERO && (t == TYPE_TS_REQUEST || t == TYPE_TS_REPLY);
   // odd byte count pads the last byte with a zero low byte
   assign final_sum = q_data.odd ? ones_add(q_data.sum, {q_data.pending, 8'h00})
                                 : q_data.sum;

   always_comb begin
      status_d  = STATUS_OK;
      matched_d = 1'b0;
      type_d    = '0;
      code_d    = '0;
      ident_d   = '0;
      seq_d     = '0;
      orig_d    = '0;
      recv_d    = '0;
      xmit_d    = '0;
      unused_d  = '0;
      plen_d    = '0;
      if (cnt < SUM_COUNT_BITS'(HEADER_BYTES)) begin
         status_d = STATUS_SHORT_HEADER;
      end else begin
         type_d    = t;
         code_d    = c;
         matched_d = is_echo || is_unr || is_ts;
         if (matched_d) begin
            if (cnt < SUM_COUNT_BITS'(is_ts ? TS_BODY_END : FIXED_BODY_END)) begin
               status_d = STATUS_SHORT_BODY;
            end else begin
               if (is_unr) begin
                  unused_d = q_data.id_seq;
               end else begin
                  ident_d = q_data.id_seq[31:16];
                  seq_d   = q_data.id_seq[15:0];
               end
               if (is_ts) begin
                  orig_d = q_data.time0;
                  recv_d = q_data.time1;
                  xmit_d = q_data.time2;
               end else begin
                  plen_d = 16'(cnt - SUM_COUNT_BITS'(FIXED_BODY_END));
               end
               if (is_ts && cnt > SUM_COUNT_BITS'(TS_BODY_END)) begin
                  status_d = STATUS_TRAILING;
               end else if (final_sum != 16'hFFFF) begin
                  status_d = STATUS_CHECKSUM_BAD;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status_d;
         matched_ff <= matched_d;
         type_ff    <= type_d;
         code_ff    <= code_d;
         ident_ff   <= ident_d;
         seq_ff     <= seq_d;
         orig_ff    <= orig_d;
         recv_ff    <= recv_d;
         xmit_ff    <= xmit_d;
         unused_ff  <= unused_d;
         plen_ff    <= plen_d;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = status_ff;
   assign rsp.matched         = matched_ff;
   assign rsp.msg_type        = type_ff;
   assign rsp.msg_code        = code_ff;
   assign rsp.identifier      = ident_ff;
   assign rsp.sequence_number = seq_ff;
   assign rsp.originate_time  = orig_ff;
   assign rsp.receive_time    = recv_ff;
   assign rsp.transmit_time   = xmit_ff;
   assign rsp.unused_word     = unused_ff;
   assign rsp.payload_length  = plen_ff;

   `ASSERT_IMPLIES(a_short_header_empty, clock, reset,
      rsp_valid_ff && status_ff == STATUS_SHORT_HEADER, !matched_ff && type_ff == '0)
   `ASSERT_IMPLIES(a_unmatched_no_fields, clock, reset,
      rsp_valid_ff && !matched_ff,
      ident_ff == '0 && plen_ff == '0 && status_ff != STATUS_CHECKSUM_BAD)

endmodule

@@ sv/icmp_message_decoder_core.sv @@
// top level of the icmp message decoder: front, summary queue and back
//
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+-----------------------------------------
//  req_ch    | in  | valid / ready     | data_byte, last_byte
//  rsp_ch    | out | valid / ready     | status, matched, type, code, decoded fields
//
//  one byte per cycle at full rate; per byte pair the front does one 16-bit ones-complement add
//  after its last byte a result is registered in a queue entry, then in the output register
//  synchronous active-high reset clears the front state, the queue and rsp valid
//  req_ch.ready drops only when the two-entry summary queue is full, which happens only
//  while rsp_ch is stalled; bytes of a message in progress keep flowing while it has room

module icmp_message_decoder_core #(
   parameter int COUNT_BITS = imd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   imd_req_if.sink   req_ch,
   imd_rsp_if.source rsp_ch
);
   import imd_pkg::*;

   // summary transaction between front and queue
   logic        push;
   logic        push_ready;
   summary_type push_data;

   // summary transaction between queue and back
   logic        pop;
   logic        pop_valid;
   summary_type pop_data;

   // front: captures fields and folds bytes into the checksum
   imd_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_ready (push_ready),
      .q_push  (push),
      .q_data  (push_data)
   );

   // decouples the byte stream from result delivery
   imd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   // back: classification, length and checksum checks, output register
   imd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_ch)
   );

endmodule
